[sv/abl_pkg.sv]
// Package for the adaptive bandwidth limiter.
// Holds the field widths, the threshold limits and the time constants.
// Used by abl_div and adaptive_bandwidth_limiter.
package abl_pkg;

   localparam int AMOUNT_WIDTH = 24;
   localparam int NOW_WIDTH    = 48;
   localparam int WAIT_WIDTH   = 32;
   localparam int THR_WIDTH    = 16;
   localparam int RATE_WIDTH   = 32;
   localparam int COUNT_WIDTH  = 32;
   localparam int USEC_WIDTH   = 20;
   localparam int PROD_WIDTH   = COUNT_WIDTH + USEC_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(PROD_WIDTH);

   localparam logic [USEC_WIDTH-1:0]  US_PER_SEC    = USEC_WIDTH'(1000000);
   localparam logic [USEC_WIDTH-1:0]  SHORT_WAIT_US = USEC_WIDTH'(100);
   localparam logic [THR_WIDTH-1:0]   THRESH_RESET  = THR_WIDTH'(16384);
   localparam logic [THR_WIDTH-1:0]   THRESH_MIN    = THR_WIDTH'(2048);
   localparam logic [THR_WIDTH-1:0]   THRESH_MAX    = THR_WIDTH'(32768);
   localparam logic [RATE_WIDTH-1:0]  RATE_RESET    = RATE_WIDTH'(1048576);

endpackage

[sv/adaptive_bandwidth_limiter.sv]
// Top level of the adaptive bandwidth limiter: sequencer, state and result register.
// Instantiates abl_div and depends on abl_pkg.
//
//   Channel  Direction  Beat contents
//   req_     in         tdata = amount[23:0], now_us[71:24]
//   rsp_     out        tdata = wait_us[31:0], threshold_now[47:32]
//   csr_     in         data = rate_bytes_per_sec[31:0]
//
// An item that reaches the threshold with a nonzero elapsed time passes through the
// serial divider, which produces one quotient bit per cycle over 52 bits, before its
// result is formed. A zero amount or the first item goes from the accumulate step
// straight to the emit step, and any other item also passes the compare step.
// req_tready is high only while the sequencer is idle.
// A stalled rsp_ side holds the finished result, and the sequencer waits in its
// last step until the result register is free. Reset is synchronous and needs
// no clearing pass.
module adaptive_bandwidth_limiter
   import abl_pkg::*;
#(
   parameter int TIME_WIDTH = 48
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // amount, now_us
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // wait_us, threshold_now
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam int AW = ((TIME_WIDTH > PROD_WIDTH) ? TIME_WIDTH : PROD_WIDTH) + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ACC   = 3'd1;
   localparam logic [2:0] ST_CMP   = 3'd2;
   localparam logic [2:0] ST_START = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_WAIT  = 3'd5;
   localparam logic [2:0] ST_ADAPT = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [RATE_WIDTH-1:0]   rate_ff, rate_in;
   logic                    started_ff, started_in;
   logic [TIME_WIDTH-1:0]   ws_ff, ws_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [THR_WIDTH-1:0]    thr_ff, thr_in;
   logic [AMOUNT_WIDTH-1:0] amount_ff, amount_in;
   logic [TIME_WIDTH-1:0]   now_ff, now_in;
   logic [TIME_WIDTH:0]     diff_ff, diff_in;
   logic [TIME_WIDTH-1:0]   mag_ff, mag_in;
   logic [AW-1:0]           wait_ff, wait_in;
   logic [WAIT_WIDTH-1:0]   res_ff, res_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [47:0]             rsp_tdata_ff, rsp_tdata_in;

   logic                    div_start;
   logic                    div_done;
   logic [PROD_WIDTH-1:0]   product;
   logic [PROD_WIDTH-1:0]   allowed;
   logic [RATE_WIDTH-1:0]   divisor;
   logic [COUNT_WIDTH:0]    sum;
   logic [AW-1:0]           sub;
   logic [WAIT_WIDTH-1:0]   wait_sat;
   logic                    out_free;

   assign product   = PROD_WIDTH'(US_PER_SEC) * PROD_WIDTH'(count_ff);
   assign divisor   = (rate_ff == '0) ? RATE_WIDTH'(1) : rate_ff;
   assign div_start = (state_ff == ST_START);

   abl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (allowed)
   );

   assign sum      = {1'b0, count_ff} + (COUNT_WIDTH + 1)'(amount_ff);
   assign sub      = AW'(allowed) - AW'(mag_ff);
   assign wait_sat = (|wait_ff[AW-1:WAIT_WIDTH]) ? '1 : wait_ff[WAIT_WIDTH-1:0];
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in      = state_ff;
      rate_in       = rate_ff;
      started_in    = started_ff;
      ws_in         = ws_ff;
      count_in      = count_ff;
      thr_in        = thr_ff;
      amount_in     = amount_ff;
      now_in        = now_ff;
      diff_in       = diff_ff;
      mag_in        = mag_ff;
      wait_in       = wait_ff;
      res_in        = res_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (csr_valid) begin
         rate_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               amount_in = req_tdata[AMOUNT_WIDTH-1:0];
               now_in    = TIME_WIDTH'(req_tdata[AMOUNT_WIDTH +: NOW_WIDTH]);
               state_in  = ST_ACC;
            end
         end
         ST_ACC: begin
            res_in = '0;
            if (amount_ff == '0) begin
               state_in = ST_EMIT;
            end else if (!started_ff) begin
               started_in = 1'b1;
               ws_in      = now_ff;
               state_in   = ST_EMIT;
            end else begin
               count_in = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
               diff_in  = {1'b0, now_ff} - {1'b0, ws_ff};
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (count_ff >= COUNT_WIDTH'(thr_ff) && diff_ff != '0) begin
               mag_in   = diff_ff[TIME_WIDTH] ? (~diff_ff[TIME_WIDTH-1:0] + TIME_WIDTH'(1))
                                              : diff_ff[TIME_WIDTH-1:0];
               state_in = ST_START;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (diff_ff[TIME_WIDTH]) begin
               wait_in = AW'(allowed) + AW'(mag_ff);
            end else begin
               wait_in = sub[AW-1] ? '0 : sub;
            end
            state_in = ST_ADAPT;
         end
         ST_ADAPT: begin
            if (wait_ff >= AW'(US_PER_SEC)) begin
               thr_in = (thr_ff <= (THRESH_MIN << 1)) ? THRESH_MIN : (thr_ff >> 1);
            end else if (wait_ff != '0 && wait_ff < AW'(SHORT_WAIT_US)) begin
               thr_in = (thr_ff >= (THRESH_MAX >> 1)) ? THRESH_MAX : (thr_ff << 1);
            end
            res_in   = wait_sat;
            count_in = '0;
            ws_in    = now_ff + TIME_WIDTH'(wait_sat);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {thr_ff, res_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rate_ff       <= RATE_RESET;
         started_ff    <= 1'b0;
         ws_ff         <= '0;
         count_ff      <= '0;
         thr_ff        <= THRESH_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rate_ff       <= rate_in;
         started_ff    <= started_in;
         ws_ff         <= ws_in;
         count_ff      <= count_in;
         thr_ff        <= thr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      amount_ff    <= amount_in;
      now_ff       <= now_in;
      diff_ff      <= diff_in;
      mag_ff       <= mag_in;
      wait_ff      <= wait_in;
      res_ff       <= res_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

[sv/abl_div.sv]
// Restoring serial divider of the adaptive bandwidth limiter.
// Divides the byte-time product by the rate, one quotient bit per cycle.
// Depends on abl_pkg.
module abl_div
   import abl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [PROD_WIDTH-1:0] dividend,
   input  logic [RATE_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [PROD_WIDTH-1:0] quotient
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [PROD_WIDTH-1:0]    quo_ff, quo_in;
   logic [RATE_WIDTH-1:0]    rem_ff, rem_in;
   logic [RATE_WIDTH-1:0]    dsr_ff, dsr_in;
   logic [RATE_WIDTH:0]      trial;
   logic [RATE_WIDTH:0]      diff;
   logic                     fits;

   assign trial = {rem_ff, quo_ff[PROD_WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[PROD_WIDTH-2:0], fits};
         rem_in = fits ? diff[RATE_WIDTH-1:0] : trial[RATE_WIDTH-1:0];
         cnt_in = cnt_ff + DIV_CNT_WIDTH'(1);
         if (cnt_ff == DIV_CNT_WIDTH'(PROD_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
